// ----- src/adsr_pkg.sv -----
package adsr_pkg;

	localparam int unsigned TICKS_PER_SECOND = 44100;

	localparam int KEY_W      = 2;
	localparam int STAGE_W    = 3;
	localparam int LEN_W      = 24;
	localparam int STEP_W     = 25;
	localparam int SUS_W      = 16;
	localparam int LEVEL_W    = 16;
	localparam int EL_W       = 25;
	localparam int PH_W       = 25;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;
	localparam int PROD_W     = PH_W + SUS_W;

	localparam logic [PH_W-1:0]    ONE_Q24     = PH_W'(1 << 24);
	localparam logic [SUS_W-1:0]   ONE_Q15     = SUS_W'(32768);
	localparam logic [EL_W-1:0]    ELAPSED_MAX = '1;
	localparam logic [PROD_W-1:0]  ROUND_Q24   = PROD_W'(1 << 23);

	localparam logic [KEY_W-1:0] KEY_NONE    = 2'd0;
	localparam logic [KEY_W-1:0] KEY_PRESS   = 2'd1;
	localparam logic [KEY_W-1:0] KEY_RELEASE = 2'd2;

	localparam logic [STAGE_W-1:0] ST_IDLE    = 3'd0;
	localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
	localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
	localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
	localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP  = 3'd6;

	localparam int unsigned ATTACK_LEN_RST  = TICKS_PER_SECOND / 20;
	localparam int unsigned DECAY_LEN_RST   = TICKS_PER_SECOND / 5;
	localparam int unsigned RELEASE_LEN_RST = TICKS_PER_SECOND * 4;
	localparam int unsigned ATTACK_STEP_RST =
		((1 << 24) + ATTACK_LEN_RST / 2) / ATTACK_LEN_RST;
	localparam int unsigned DECAY_STEP_RST =
		((1 << 24) + DECAY_LEN_RST / 2) / DECAY_LEN_RST;
	localparam int unsigned RELEASE_STEP_RST =
		((1 << 24) + RELEASE_LEN_RST / 2) / RELEASE_LEN_RST;
	localparam int unsigned SUSTAIN_RST = 22938;

endpackage

// ----- src/adsr_envelope_generator.sv -----
// A key beat passes through the input, state and level registers in that order
// before its result shows.
// Throughput: one beat per cycle unless res_stall holds the output.
// The level multiply sits in its own stage after the phase update.
// Reset (arst_n low): stage idle, elapsed and phase zero, config registers to defaults,
// all pipeline valids cleared.
module adsr_envelope_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              key_valid,
	output logic                              key_stall,
	input  logic [adsr_pkg::KEY_W-1:0]        key_action,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [adsr_pkg::LEVEL_W-1:0]      level,
	output logic [adsr_pkg::STAGE_W-1:0]      stage,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [adsr_pkg::LEN_W-1:0]  attack_len_q, decay_len_q, release_len_q;
	logic [adsr_pkg::STEP_W-1:0] attack_step_q, decay_step_q, release_step_q;
	logic [adsr_pkg::SUS_W-1:0]  sustain_q;

	logic [adsr_pkg::STAGE_W-1:0] env_stage_q;
	logic [adsr_pkg::EL_W-1:0]    elapsed_q;
	logic [adsr_pkg::PH_W-1:0]    phase_q;

	logic                         valid_s1;
	logic [adsr_pkg::KEY_W-1:0]   key_s1;

	logic                         valid_s2;
	logic [adsr_pkg::STAGE_W-1:0] lvl_stage_s2;
	logic [adsr_pkg::STAGE_W-1:0] stage_s2;
	logic [adsr_pkg::PH_W-1:0]    phase_s2;
	logic [adsr_pkg::SUS_W-1:0]   sus_s2;

	logic                         res_valid_q;
	logic [adsr_pkg::LEVEL_W-1:0] level_q;
	logic [adsr_pkg::STAGE_W-1:0] stage_out_q;

	logic out_ready, s2_ready, s1_ready;
	logic move_s1, move_s2;

	assign out_ready = !res_valid_q || !res_stall;
	assign s2_ready  = !valid_s2 || out_ready;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign move_s1   = valid_s1 && s2_ready;
	assign move_s2   = valid_s2 && out_ready;
	assign key_stall = !s1_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q   <= adsr_pkg::LEN_W'(adsr_pkg::ATTACK_LEN_RST);
			attack_step_q  <= adsr_pkg::STEP_W'(adsr_pkg::ATTACK_STEP_RST);
			decay_len_q    <= adsr_pkg::LEN_W'(adsr_pkg::DECAY_LEN_RST);
			decay_step_q   <= adsr_pkg::STEP_W'(adsr_pkg::DECAY_STEP_RST);
			sustain_q      <= adsr_pkg::SUS_W'(adsr_pkg::SUSTAIN_RST);
			release_len_q  <= adsr_pkg::LEN_W'(adsr_pkg::RELEASE_LEN_RST);
			release_step_q <= adsr_pkg::STEP_W'(adsr_pkg::RELEASE_STEP_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				adsr_pkg::REG_ATTACK_LEN:    attack_len_q   <= cfg_data[adsr_pkg::LEN_W-1:0];
				adsr_pkg::REG_ATTACK_STEP:   attack_step_q  <= cfg_data;
				adsr_pkg::REG_DECAY_LEN:     decay_len_q    <= cfg_data[adsr_pkg::LEN_W-1:0];
				adsr_pkg::REG_DECAY_STEP:    decay_step_q   <= cfg_data;
				adsr_pkg::REG_SUSTAIN_LEVEL: sustain_q      <= cfg_data[adsr_pkg::SUS_W-1:0];
				adsr_pkg::REG_RELEASE_LEN:   release_len_q  <= cfg_data[adsr_pkg::LEN_W-1:0];
				adsr_pkg::REG_RELEASE_STEP:  release_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= key_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && key_valid) begin
			key_s1 <= key_action;
		end
	end

	// state update
	logic [adsr_pkg::STAGE_W-1:0] st, lvl_st, nxt_st;
	logic [adsr_pkg::EL_W-1:0]    el, el_inc;
	logic [adsr_pkg::PH_W-1:0]    ph, ph_new;
	logic [adsr_pkg::STEP_W-1:0]  step;
	logic [adsr_pkg::LEN_W-1:0]   len;
	logic [adsr_pkg::PH_W:0]      psum;
	logic                         timed, done;
	logic [adsr_pkg::SUS_W-1:0]   sus;

	always_comb begin
		st = env_stage_q;
		el = elapsed_q;
		ph = phase_q;
		if (key_s1 == adsr_pkg::KEY_PRESS) begin
			st = adsr_pkg::ST_ATTACK;
			el = '0;
			ph = '0;
		end else if (key_s1 == adsr_pkg::KEY_RELEASE) begin
			st = adsr_pkg::ST_RELEASE;
			el = '0;
			ph = '0;
		end
		el_inc = (el == adsr_pkg::ELAPSED_MAX) ? el : el + adsr_pkg::EL_W'(1);

		timed  = 1'b0;
		step   = '0;
		len    = '0;
		lvl_st = st;
		case (st)
			adsr_pkg::ST_ATTACK: begin
				timed = 1'b1;
				step  = attack_step_q;
				len   = attack_len_q;
			end
			adsr_pkg::ST_DECAY: begin
				timed = 1'b1;
				step  = decay_step_q;
				len   = decay_len_q;
			end
			adsr_pkg::ST_RELEASE: begin
				timed = 1'b1;
				step  = release_step_q;
				len   = release_len_q;
			end
			adsr_pkg::ST_SUSTAIN: ;
			default: lvl_st = adsr_pkg::ST_IDLE;
		endcase

		psum = {1'b0, ph} + {1'b0, step};
		if (!timed) begin
			ph_new = ph;
		end else if (psum > {1'b0, adsr_pkg::ONE_Q24}) begin
			ph_new = adsr_pkg::ONE_Q24;
		end else begin
			ph_new = psum[adsr_pkg::PH_W-1:0];
		end

		done = timed && (el_inc > {1'b0, len});
		case (lvl_st)
			adsr_pkg::ST_ATTACK: nxt_st = adsr_pkg::ST_DECAY;
			adsr_pkg::ST_DECAY:  nxt_st = adsr_pkg::ST_SUSTAIN;
			default:             nxt_st = adsr_pkg::ST_IDLE;
		endcase
		if (!done) begin
			nxt_st = lvl_st;
		end

		sus = (sustain_q > adsr_pkg::ONE_Q15) ? adsr_pkg::ONE_Q15 : sustain_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_stage_q <= adsr_pkg::ST_IDLE;
			elapsed_q   <= '0;
			phase_q     <= '0;
			valid_s2    <= 1'b0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (move_s1) begin
				env_stage_q <= nxt_st;
				elapsed_q   <= done ? '0 : el_inc;
				phase_q     <= done ? '0 : ph_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			lvl_stage_s2 <= lvl_st;
			stage_s2     <= nxt_st;
			phase_s2     <= ph_new;
			sus_s2       <= sus;
		end
	end

	// stage 2: level
	logic                         is_decay;
	logic [adsr_pkg::PH_W-1:0]    mul_a;
	logic [adsr_pkg::SUS_W-1:0]   mul_b;
	logic [adsr_pkg::PROD_W-1:0]  prod, prod_rnd;
	logic [adsr_pkg::LEVEL_W-1:0] scaled;
	logic [adsr_pkg::PH_W:0]      att_sum;
	logic [adsr_pkg::LEVEL_W-1:0] lvl;

	always_comb begin
		is_decay = (lvl_stage_s2 == adsr_pkg::ST_DECAY);
		mul_a    = is_decay ? phase_s2 : adsr_pkg::ONE_Q24 - phase_s2;
		mul_b    = is_decay ? adsr_pkg::ONE_Q15 - sus_s2 : sus_s2;
		prod     = adsr_pkg::PROD_W'(mul_a) * adsr_pkg::PROD_W'(mul_b);
		prod_rnd = prod + adsr_pkg::ROUND_Q24;
		scaled   = prod_rnd[24 +: adsr_pkg::LEVEL_W];
		att_sum  = {1'b0, phase_s2} + (adsr_pkg::PH_W + 1)'(256);
		case (lvl_stage_s2)
			adsr_pkg::ST_ATTACK:  lvl = att_sum[9 +: adsr_pkg::LEVEL_W];
			adsr_pkg::ST_DECAY:   lvl = adsr_pkg::ONE_Q15 - scaled;
			adsr_pkg::ST_SUSTAIN: lvl = sus_s2;
			adsr_pkg::ST_RELEASE: lvl = scaled;
			default:              lvl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_ready) begin
			res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			level_q     <= lvl;
			stage_out_q <= stage_s2;
		end
	end

	assign res_valid = res_valid_q;
	assign level     = level_q;
	assign stage     = stage_out_q;

endmodule

// ----- src/adsr_checker.sv -----
module adsr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              key_valid,
	input logic                              key_stall,
	input logic                              res_valid,
	input logic                              res_stall,
	input logic [adsr_pkg::LEVEL_W-1:0]      level,
	input logic [adsr_pkg::STAGE_W-1:0]      stage,
	input logic                              cfg_valid,
	input logic                              cfg_ready
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(level) && $stable(stage))
		else $error("result changed while stalled");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> level <= adsr_pkg::ONE_Q15)
		else $error("level above full scale");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write not taken");

	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && $past(!key_valid && !res_valid) && $past(!key_valid, 2)
			&& $past(!res_valid, 2) |-> !key_stall)
		else $error("input stalled with empty pipeline");

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.key_valid (key_valid),
	.key_stall (key_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.level     (level),
	.stage     (stage),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

// ----- verif/tb_adsr_envelope_generator.sv -----
`timescale 1ns / 100ps

module tb_adsr_envelope_generator;

	localparam logic [adsr_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam logic [adsr_pkg::KEY_W-1:0] KEY_SPARE = 2'd3;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [adsr_pkg::LEVEL_W-1:0] level;
		logic [adsr_pkg::STAGE_W-1:0] stage;
	} env_beat_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            key_valid = 1'b0;
	logic                            key_stall;
	logic [adsr_pkg::KEY_W-1:0]      key_action = adsr_pkg::KEY_NONE;
	logic                            res_valid;
	logic                            res_stall = 1'b0;
	logic [adsr_pkg::LEVEL_W-1:0]    level;
	logic [adsr_pkg::STAGE_W-1:0]    stage;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index = adsr_pkg::REG_ATTACK_LEN;
	logic [adsr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// envelope state and register copy
	logic [adsr_pkg::LEN_W-1:0]   atk_len, dec_len, rel_len;
	logic [adsr_pkg::STEP_W-1:0]  atk_step, dec_step, rel_step;
	logic [adsr_pkg::SUS_W-1:0]   sus_level;
	logic [adsr_pkg::STAGE_W-1:0] env_stage;
	logic [adsr_pkg::EL_W-1:0]    env_ticks;
	logic [adsr_pkg::PH_W-1:0]    env_phase;

	env_beat_t envelope_q[$];
	int        mismatches = 0;
	bit        quiet = 1'b0;

	adsr_envelope_generator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.key_action (key_action),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.level      (level),
		.stage      (stage),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		res_stall <= !quiet && ($urandom_range(0, 99) < 10);
	end

	function automatic env_beat_t next_envelope(logic [adsr_pkg::KEY_W-1:0] ev);
		logic [adsr_pkg::SUS_W-1:0]   s;
		logic [adsr_pkg::STEP_W-1:0]  step;
		logic [adsr_pkg::LEN_W-1:0]   len;
		logic [adsr_pkg::PH_W:0]      psum;
		logic [63:0]                  prod;
		logic [adsr_pkg::LEVEL_W-1:0] lvl;
		bit                           timed;
		env_beat_t                    r;
		s = (sus_level > adsr_pkg::ONE_Q15) ? adsr_pkg::ONE_Q15 : sus_level;
		step = '0;
		len = '0;
		timed = 1'b0;
		lvl = '0;
		if (ev == adsr_pkg::KEY_PRESS) begin
			env_stage = adsr_pkg::ST_ATTACK;
			env_ticks = '0;
			env_phase = '0;
		end else if (ev == adsr_pkg::KEY_RELEASE) begin
			env_stage = adsr_pkg::ST_RELEASE;
			env_ticks = '0;
			env_phase = '0;
		end
		if (env_ticks != adsr_pkg::ELAPSED_MAX)
			env_ticks = env_ticks + 1'b1;
		case (env_stage)
			adsr_pkg::ST_ATTACK: begin
				step = atk_step; len = atk_len; timed = 1'b1;
			end
			adsr_pkg::ST_DECAY: begin
				step = dec_step; len = dec_len; timed = 1'b1;
			end
			adsr_pkg::ST_RELEASE: begin
				step = rel_step; len = rel_len; timed = 1'b1;
			end
			default: ;
		endcase
		if (timed) begin
			psum = {1'b0, env_phase} + {1'b0, step};
			env_phase = (psum > adsr_pkg::ONE_Q24) ? adsr_pkg::ONE_Q24 :
				psum[adsr_pkg::PH_W-1:0];
		end
		case (env_stage)
			adsr_pkg::ST_ATTACK:
				lvl = adsr_pkg::LEVEL_W'((64'(env_phase) + 64'd256) >> 9);
			adsr_pkg::ST_DECAY: begin
				prod = 64'(env_phase) * 64'(adsr_pkg::ONE_Q15 - s);
				lvl = adsr_pkg::ONE_Q15 -
					adsr_pkg::LEVEL_W'((prod + 64'(adsr_pkg::ROUND_Q24)) >> 24);
			end
			adsr_pkg::ST_SUSTAIN: lvl = s;
			adsr_pkg::ST_RELEASE: begin
				prod = 64'(adsr_pkg::ONE_Q24 - env_phase) * 64'(s);
				lvl = adsr_pkg::LEVEL_W'((prod + 64'(adsr_pkg::ROUND_Q24)) >> 24);
			end
			default: begin
				env_stage = adsr_pkg::ST_IDLE;
				lvl = '0;
			end
		endcase
		if (timed && env_ticks > adsr_pkg::EL_W'(len)) begin
			if (env_stage == adsr_pkg::ST_ATTACK)
				env_stage = adsr_pkg::ST_DECAY;
			else if (env_stage == adsr_pkg::ST_DECAY)
				env_stage = adsr_pkg::ST_SUSTAIN;
			else
				env_stage = adsr_pkg::ST_IDLE;
			env_ticks = '0;
			env_phase = '0;
		end
		r.level = lvl;
		r.stage = env_stage;
		return r;
	endfunction

	always @(posedge clk) begin
		env_beat_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (envelope_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected beat: level %0d stage %0d", level, stage);
			end else begin
				want = envelope_q.pop_front();
				if (level !== want.level || stage !== want.stage) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: level exp %0d got %0d, stage exp %0d got %0d",
							want.level, level, want.stage, stage);
				end
			end
		end
	end

	task automatic send_key(logic [adsr_pkg::KEY_W-1:0] ev);
		if (!quiet) begin
			while ($urandom_range(0, 99) < 10) begin
				key_valid  <= 1'b0;
				key_action <= adsr_pkg::KEY_W'($urandom);
				@(posedge clk);
			end
		end
		key_valid  <= 1'b1;
		key_action <= ev;
		@(posedge clk);
		while (key_stall)
			@(posedge clk);
		envelope_q.push_back(next_envelope(ev));
	endtask

	task automatic end_keys();
		key_valid <= 1'b0;
		while (envelope_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// leaves cfg_valid high; cfg_done lowers it after a batch
	task automatic cfg_put(logic [adsr_pkg::CFG_IDX_W-1:0] idx,
		logic [adsr_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			adsr_pkg::REG_ATTACK_LEN:    atk_len   = data[adsr_pkg::LEN_W-1:0];
			adsr_pkg::REG_ATTACK_STEP:   atk_step  = data[adsr_pkg::STEP_W-1:0];
			adsr_pkg::REG_DECAY_LEN:     dec_len   = data[adsr_pkg::LEN_W-1:0];
			adsr_pkg::REG_DECAY_STEP:    dec_step  = data[adsr_pkg::STEP_W-1:0];
			adsr_pkg::REG_SUSTAIN_LEVEL: sus_level = data[adsr_pkg::SUS_W-1:0];
			adsr_pkg::REG_RELEASE_LEN:   rel_len   = data[adsr_pkg::LEN_W-1:0];
			adsr_pkg::REG_RELEASE_STEP:  rel_step  = data[adsr_pkg::STEP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic cfg_done();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [adsr_pkg::LEN_W-1:0] pick_len();
		case ($urandom_range(0, 9))
			0:       return '0;
			8:       return adsr_pkg::LEN_W'($urandom_range(13, 60));
			9:       return adsr_pkg::LEN_W'($urandom);
			default: return adsr_pkg::LEN_W'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [adsr_pkg::STEP_W-1:0] pick_step(
		logic [adsr_pkg::LEN_W-1:0] len);
		case ($urandom_range(0, 9))
			0:       return adsr_pkg::STEP_W'($urandom);
			1:       return '0;
			2:       return adsr_pkg::STEP_W'(adsr_pkg::ONE_Q24);
			3:       return '1;
			default: return (len == 0) ? adsr_pkg::STEP_W'(adsr_pkg::ONE_Q24) :
				adsr_pkg::STEP_W'(((64'd1 << 24) + 64'(len / 2)) / 64'(len));
		endcase
	endfunction

	function automatic logic [adsr_pkg::SUS_W-1:0] pick_sustain();
		case ($urandom_range(0, 9))
			0:       return adsr_pkg::SUS_W'($urandom);
			1:       return adsr_pkg::ONE_Q15;
			2:       return '0;
			default: return adsr_pkg::SUS_W'($urandom_range(0, 32768));
		endcase
	endfunction

	task automatic test_default_envelope();
		send_key(adsr_pkg::KEY_PRESS);
		send_key(adsr_pkg::KEY_NONE);
		send_key(adsr_pkg::KEY_NONE);
		send_key(KEY_SPARE);
		send_key(adsr_pkg::KEY_RELEASE);
		send_key(adsr_pkg::KEY_NONE);
		send_key(adsr_pkg::KEY_PRESS);
		send_key(adsr_pkg::KEY_RELEASE);
		end_keys();
	endtask

	task automatic test_corner_settings();
		// one-tick attack, oversized step and sustain, one-tick release
		cfg_put(adsr_pkg::REG_ATTACK_LEN, '0);
		cfg_put(adsr_pkg::REG_ATTACK_STEP, '1);
		cfg_put(adsr_pkg::REG_DECAY_LEN, 25'd1);
		cfg_put(adsr_pkg::REG_DECAY_STEP, '0);
		cfg_put(adsr_pkg::REG_SUSTAIN_LEVEL, 25'hFFFF);
		cfg_put(adsr_pkg::REG_RELEASE_LEN, '0);
		cfg_put(adsr_pkg::REG_RELEASE_STEP, adsr_pkg::CFG_DATA_W'(adsr_pkg::ONE_Q24));
		cfg_put(REG_NONE, adsr_pkg::CFG_DATA_W'($urandom));
		cfg_done();
		send_key(adsr_pkg::KEY_PRESS);
		send_key(adsr_pkg::KEY_NONE);
		send_key(adsr_pkg::KEY_NONE);
		send_key(adsr_pkg::KEY_NONE);
		send_key(KEY_SPARE);
		send_key(adsr_pkg::KEY_RELEASE);
		send_key(adsr_pkg::KEY_NONE);
		end_keys();
		// frozen attack, instant decay, zero sustain, endless release
		cfg_put(adsr_pkg::REG_ATTACK_LEN, 25'd2);
		cfg_put(adsr_pkg::REG_ATTACK_STEP, '0);
		cfg_put(adsr_pkg::REG_DECAY_LEN, '0);
		cfg_put(adsr_pkg::REG_DECAY_STEP, adsr_pkg::CFG_DATA_W'(adsr_pkg::ONE_Q24));
		cfg_put(adsr_pkg::REG_SUSTAIN_LEVEL, '0);
		cfg_put(adsr_pkg::REG_RELEASE_LEN, 25'hFF_FFFF);
		cfg_put(adsr_pkg::REG_RELEASE_STEP, 25'd1);
		cfg_done();
		send_key(adsr_pkg::KEY_RELEASE);
		send_key(adsr_pkg::KEY_NONE);
		send_key(adsr_pkg::KEY_PRESS);
		repeat (5) send_key(adsr_pkg::KEY_NONE);
		send_key(adsr_pkg::KEY_PRESS);
		send_key(adsr_pkg::KEY_RELEASE);
		send_key(adsr_pkg::KEY_NONE);
		end_keys();
	endtask

	task automatic test_random_notes(int phases, int per_phase);
		logic [adsr_pkg::LEN_W-1:0] len;
		int sent;
		int hold;
		int tail;
		for (int p = 0; p < phases; p++) begin
			len = pick_len();
			cfg_put(adsr_pkg::REG_ATTACK_LEN, adsr_pkg::CFG_DATA_W'(len));
			cfg_put(adsr_pkg::REG_ATTACK_STEP, pick_step(len));
			len = pick_len();
			cfg_put(adsr_pkg::REG_DECAY_LEN, adsr_pkg::CFG_DATA_W'(len));
			cfg_put(adsr_pkg::REG_DECAY_STEP, pick_step(len));
			cfg_put(adsr_pkg::REG_SUSTAIN_LEVEL, adsr_pkg::CFG_DATA_W'(pick_sustain()));
			len = pick_len();
			cfg_put(adsr_pkg::REG_RELEASE_LEN, adsr_pkg::CFG_DATA_W'(len));
			cfg_put(adsr_pkg::REG_RELEASE_STEP, pick_step(len));
			if ($urandom_range(0, 2) == 0)
				cfg_put(REG_NONE, adsr_pkg::CFG_DATA_W'($urandom));
			cfg_done();
			quiet = (p == 2);
			sent = 0;
			while (sent < per_phase) begin
				if ($urandom_range(0, 3) != 0) begin
					send_key(adsr_pkg::KEY_PRESS);
					hold = $urandom_range(0, 30);
					repeat (hold) send_key(adsr_pkg::KEY_NONE);
					send_key(adsr_pkg::KEY_RELEASE);
					tail = $urandom_range(0, 20);
					repeat (tail) send_key(adsr_pkg::KEY_NONE);
					sent += hold + tail + 2;
				end else begin
					send_key(adsr_pkg::KEY_W'($urandom));
					sent++;
				end
			end
			quiet = 1'b0;
			end_keys();
		end
	endtask

	initial begin
		atk_len   = adsr_pkg::LEN_W'(adsr_pkg::ATTACK_LEN_RST);
		atk_step  = adsr_pkg::STEP_W'(adsr_pkg::ATTACK_STEP_RST);
		dec_len   = adsr_pkg::LEN_W'(adsr_pkg::DECAY_LEN_RST);
		dec_step  = adsr_pkg::STEP_W'(adsr_pkg::DECAY_STEP_RST);
		sus_level = adsr_pkg::SUS_W'(adsr_pkg::SUSTAIN_RST);
		rel_len   = adsr_pkg::LEN_W'(adsr_pkg::RELEASE_LEN_RST);
		rel_step  = adsr_pkg::STEP_W'(adsr_pkg::RELEASE_STEP_RST);
		env_stage = adsr_pkg::ST_IDLE;
		env_ticks = '0;
		env_phase = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_envelope();
		test_corner_settings();
		test_random_notes(6, 100);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && envelope_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#3ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
